FILE: hdl/gmb_pkg.sv
// Shared types, codes and constants of the grid maze breadth-first search block.
package gmb_pkg;

   // Field widths that are fixed by the interface.
   localparam int SIDE_W  = 6;
   localparam int COORD_W = 5;
   localparam int PASS_W  = 3;
   localparam int CMD_W   = 2;
   localparam int DIR_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

   // Neighbor directions, in visiting order.
   localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
   localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd1;
   localparam logic [DIR_W-1:0] DIR_EAST  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COLUMN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_COLUMN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_ROW     = 3'd5;

   // Configuration reset values.
   localparam logic [SIDE_W-1:0]  RST_ROW_COUNT    = 6'd32;
   localparam logic [SIDE_W-1:0]  RST_COLUMN_COUNT = 6'd32;
   localparam logic [COORD_W-1:0] RST_START_COLUMN = 5'd0;
   localparam logic [COORD_W-1:0] RST_START_ROW    = 5'd0;
   localparam logic [COORD_W-1:0] RST_GOAL_COLUMN  = 5'd31;
   localparam logic [COORD_W-1:0] RST_GOAL_ROW     = 5'd31;

   typedef struct packed {
      logic [SIDE_W-1:0]  row_count;
      logic [SIDE_W-1:0]  column_count;
      logic [COORD_W-1:0] start_column;
      logic [COORD_W-1:0] start_row;
      logic [COORD_W-1:0] goal_column;
      logic [COORD_W-1:0] goal_row;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [COORD_W-1:0] cell_column;
      logic [COORD_W-1:0] cell_row;
      logic [PASS_W-1:0]  cell_passage;
   } item_type;

   typedef struct packed {
      logic [COORD_W-1:0] visit_column;
      logic [COORD_W-1:0] visit_row;
      logic               found;
      logic               exhausted;
      logic               bad_goal;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_START,
      ST_POP,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_CHECK,
      ST_HERE,
      ST_NREAD,
      ST_NEVAL,
      ST_RESULT
   } state_type;

endpackage

FILE: hdl/gmb_div.sv
// Iterative restoring divider: one quotient bit per cycle.
module gmb_div #(
   parameter int NUM_W = 10,
   parameter int DEN_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             busy,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);

   localparam int CNT_W = (NUM_W > 2) ? $clog2(NUM_W) : 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   // One shift-and-subtract step on the partial remainder.
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/gmb_core.sv
// Search sequencer with the passage, visited and queue memories.
module gmb_core #(
   parameter int MAX_SIDE = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  gmb_pkg::cfg_type    cfg,
   input  logic                item_take,
   input  gmb_pkg::item_type   item,
   output logic                idle,
   output logic                res_valid,
   input  logic                res_take,
   output gmb_pkg::result_type res
);

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int CW    = $clog2(DEPTH);
   localparam int SW    = gmb_pkg::SIDE_W;
   localparam int PW    = gmb_pkg::PASS_W;
   localparam int WW    = CW + SW;
   localparam logic [CW:0]   DEPTH_C  = (CW+1)'(DEPTH);
   localparam logic [CW-1:0] LAST_IDX = CW'(DEPTH - 1);
   localparam logic [WW-1:0] ONE_W    = WW'(1);

   // Memories.
   logic [PW-1:0] passage_mem_ff [DEPTH];
   logic          visited_mem_ff [DEPTH];
   logic [CW-1:0] queue_mem_ff   [DEPTH];

   logic          pass_we;
   logic [CW-1:0] pass_wa, pass_ra;
   logic [PW-1:0] pass_wd;
   logic [PW-1:0] passage_rd_ff;
   logic          vis_we, vis_wd;
   logic [CW-1:0] vis_wa, vis_ra;
   logic          visited_rd_ff;
   logic          q_we;
   logic [CW-1:0] q_wa, q_wd, q_ra;
   logic [CW-1:0] queue_rd_ff;

   // Sequencer state.
   gmb_pkg::state_type  state_ff, state_in;
   logic [gmb_pkg::DIR_W-1:0] dir_ff, dir_in;
   logic [CW-1:0]       head_ff, head_in;
   logic [CW:0]         count_ff, count_in;
   logic [CW-1:0]       sweep_ff, sweep_in;
   logic                begin_ff, begin_in;
   logic [CW-1:0]       cell_ff, cell_in;
   logic [SW-1:0]       col_ff, col_in;
   logic [CW-1:0]       row_ff, row_in;
   logic [PW-1:0]       here_ff, here_in;
   logic [CW-1:0]       nidx_ff, nidx_in;
   gmb_pkg::result_type res_ff, res_in;

   // Divider hookup.
   logic          div_start;
   logic [CW-1:0] div_dividend;
   logic          div_busy;
   logic [CW-1:0] div_quo;
   logic [SW-1:0] div_rem;

   // Derived values.
   logic [SW-1:0] rows, cols;
   logic [WW-1:0] rows_w, cols_w, row_w, col_w, cell_w;
   logic [CW:0]   tail_sum;
   logic [CW-1:0] tail;
   logic [CW-1:0] head_next;
   logic          has_room;
   logic          ld_ok;
   logic [WW-1:0] ld_w;
   logic          start_ok;
   logic [WW-1:0] start_w;
   logic          bad_goal;
   logic          is_goal;
   logic          nb_ok;
   logic [WW-1:0] nb_w;
   logic          linked;
   logic [CW-1:0] popped;

   gmb_div #(
      .NUM_W (CW),
      .DEN_W (SW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (cols),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Grid size in use: zero acts as one, anything above the maximum is clamped.
   always_comb begin
      if (cfg.row_count == '0) begin
         rows = SW'(1);
      end else if (32'(cfg.row_count) > MAX_SIDE) begin
         rows = SW'(MAX_SIDE);
      end else begin
         rows = cfg.row_count;
      end
      if (cfg.column_count == '0) begin
         cols = SW'(1);
      end else if (32'(cfg.column_count) > MAX_SIDE) begin
         cols = SW'(MAX_SIDE);
      end else begin
         cols = cfg.column_count;
      end
   end

   // Queue pointers, bounds checks and cell indexes.
   always_comb begin
      rows_w   = WW'(rows);
      cols_w   = WW'(cols);
      row_w    = WW'(row_ff);
      col_w    = WW'(col_ff);
      cell_w   = WW'(cell_ff);
      tail_sum = {1'b0, head_ff} + count_ff;
      tail     = (tail_sum >= DEPTH_C) ? CW'(tail_sum - DEPTH_C) : CW'(tail_sum);
      head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
      has_room = (count_ff < DEPTH_C);
      popped   = ({1'b0, queue_rd_ff} >= DEPTH_C) ? '0 : queue_rd_ff;

      ld_ok = ({1'b0, item.cell_column} < cols) && ({1'b0, item.cell_row} < rows);
      ld_w  = WW'(item.cell_row) * cols_w + WW'(item.cell_column);

      bad_goal = ({1'b0, cfg.goal_column} >= cols) || ({1'b0, cfg.goal_row} >= rows);
      start_ok = ({1'b0, cfg.start_column} < cols) && ({1'b0, cfg.start_row} < rows);
      start_w  = WW'(cfg.start_row) * cols_w + WW'(cfg.start_column);

      is_goal = (col_w == WW'(cfg.goal_column)) && (row_w == WW'(cfg.goal_row));

      // Neighbor in the current direction: in bounds, and its index.
      case (dir_ff)
         gmb_pkg::DIR_NORTH: begin
            nb_ok = (row_w != '0) && ((row_w - ONE_W) < rows_w) && (col_w < cols_w);
            nb_w  = cell_w - cols_w;
         end
         gmb_pkg::DIR_SOUTH: begin
            nb_ok = ((row_w + ONE_W) < rows_w) && (col_w < cols_w);
            nb_w  = cell_w + cols_w;
         end
         gmb_pkg::DIR_EAST: begin
            nb_ok = ((col_w + ONE_W) < cols_w) && (row_w < rows_w);
            nb_w  = cell_w + ONE_W;
         end
         gmb_pkg::DIR_WEST: begin
            nb_ok = (col_w != '0) && ((col_w - ONE_W) < cols_w) && (row_w < rows_w);
            nb_w  = cell_w - ONE_W;
         end
         default: begin
            nb_ok = 1'b0;
            nb_w  = cell_w;
         end
      endcase

      // Joined when this cell points at the neighbor or the neighbor points back.
      linked = (here_ff == PW'(dir_ff))
               || (passage_rd_ff == PW'(dir_ff ^ gmb_pkg::DIR_SOUTH));
   end

   // Next state, memory port control and outputs.
   always_comb begin
      state_in     = state_ff;
      dir_in       = dir_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      sweep_in     = sweep_ff;
      begin_in     = begin_ff;
      cell_in      = cell_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      here_in      = here_ff;
      nidx_in      = nidx_ff;
      res_in       = res_ff;
      pass_we      = 1'b0;
      pass_wa      = '0;
      pass_wd      = '0;
      pass_ra      = '0;
      vis_we       = 1'b0;
      vis_wa       = '0;
      vis_wd       = 1'b0;
      vis_ra       = '0;
      q_we         = 1'b0;
      q_wa         = tail;
      q_wd         = '0;
      q_ra         = head_ff;
      div_start    = 1'b0;
      div_dividend = popped;
      idle         = 1'b0;
      res_valid    = 1'b0;

      case (state_ff)
         gmb_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (item_take) begin
               case (item.command)
                  gmb_pkg::CMD_LOAD: begin
                     pass_we = ld_ok;
                     pass_wa = CW'(ld_w);
                     pass_wd = item.cell_passage;
                  end
                  gmb_pkg::CMD_BEGIN: begin
                     head_in  = '0;
                     count_in = '0;
                     sweep_in = '0;
                     begin_in = 1'b1;
                     state_in = gmb_pkg::ST_CLEAR;
                  end
                  gmb_pkg::CMD_STEP: begin
                     state_in = gmb_pkg::ST_POP;
                  end
                  default: begin
                     state_in = gmb_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         // Sweep the visited map to zero, one entry a cycle.
         gmb_pkg::ST_CLEAR: begin
            vis_we   = 1'b1;
            vis_wa   = sweep_ff;
            vis_wd   = 1'b0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_IDX) begin
               state_in = begin_ff ? gmb_pkg::ST_START : gmb_pkg::ST_IDLE;
            end
         end

         // Enqueue the start cell unless the goal or the start is off the grid.
         gmb_pkg::ST_START: begin
            res_in          = '0;
            res_in.bad_goal = bad_goal;
            if (!bad_goal && start_ok) begin
               q_we     = 1'b1;
               q_wd     = CW'(start_w);
               vis_we   = 1'b1;
               vis_wa   = CW'(start_w);
               vis_wd   = 1'b1;
               count_in = count_ff + 1'b1;
            end
            state_in = gmb_pkg::ST_RESULT;
         end

         gmb_pkg::ST_POP: begin
            res_in = '0;
            if (count_ff == '0) begin
               res_in.exhausted = 1'b1;
               state_in         = gmb_pkg::ST_RESULT;
            end else begin
               q_ra     = head_ff;
               head_in  = head_next;
               count_in = count_ff - 1'b1;
               state_in = gmb_pkg::ST_DIV_GO;
            end
         end

         // Split the popped index into column and row.
         gmb_pkg::ST_DIV_GO: begin
            cell_in   = popped;
            div_start = 1'b1;
            state_in  = gmb_pkg::ST_DIV_WAIT;
         end

         gmb_pkg::ST_DIV_WAIT: begin
            if (!div_busy) begin
               col_in   = div_rem;
               row_in   = div_quo;
               state_in = gmb_pkg::ST_CHECK;
            end
         end

         gmb_pkg::ST_CHECK: begin
            res_in.visit_column = gmb_pkg::COORD_W'(col_ff);
            res_in.visit_row    = gmb_pkg::COORD_W'(row_ff);
            if (is_goal) begin
               res_in.found = 1'b1;
               state_in     = gmb_pkg::ST_RESULT;
            end else begin
               pass_ra  = cell_ff;
               state_in = gmb_pkg::ST_HERE;
            end
         end

         gmb_pkg::ST_HERE: begin
            here_in  = passage_rd_ff;
            dir_in   = gmb_pkg::DIR_NORTH;
            state_in = gmb_pkg::ST_NREAD;
         end

         // Fetch the neighbor's passage and visited bit, or skip it.
         gmb_pkg::ST_NREAD: begin
            if (nb_ok) begin
               pass_ra  = CW'(nb_w);
               vis_ra   = CW'(nb_w);
               nidx_in  = CW'(nb_w);
               state_in = gmb_pkg::ST_NEVAL;
            end else if (dir_ff == gmb_pkg::DIR_WEST) begin
               state_in = gmb_pkg::ST_RESULT;
            end else begin
               dir_in = dir_ff + 1'b1;
            end
         end

         // Push the neighbor when it is joined, not yet visited and the queue has room.
         gmb_pkg::ST_NEVAL: begin
            if (!visited_rd_ff && linked && has_room) begin
               q_we     = 1'b1;
               q_wd     = nidx_ff;
               vis_we   = 1'b1;
               vis_wa   = nidx_ff;
               vis_wd   = 1'b1;
               count_in = count_ff + 1'b1;
            end
            if (dir_ff == gmb_pkg::DIR_WEST) begin
               state_in = gmb_pkg::ST_RESULT;
            end else begin
               dir_in   = dir_ff + 1'b1;
               state_in = gmb_pkg::ST_NREAD;
            end
         end

         gmb_pkg::ST_RESULT: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = gmb_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = gmb_pkg::ST_IDLE;
         end
      endcase
   end

   // State register; reset starts a clearing pass over the visited map.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gmb_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         sweep_ff <= '0;
         begin_ff <= 1'b0;
         dir_ff   <= gmb_pkg::DIR_NORTH;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         sweep_ff <= sweep_in;
         begin_ff <= begin_in;
         dir_ff   <= dir_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      here_ff <= here_in;
      nidx_ff <= nidx_in;
      res_ff  <= res_in;
   end

   // Passage memory.
   always_ff @(posedge clock) begin
      if (pass_we) begin
         passage_mem_ff[pass_wa] <= pass_wd;
      end
      passage_rd_ff <= passage_mem_ff[pass_ra];
   end

   // Visited memory.
   always_ff @(posedge clock) begin
      if (vis_we) begin
         visited_mem_ff[vis_wa] <= vis_wd;
      end
      visited_rd_ff <= visited_mem_ff[vis_ra];
   end

   // Pending queue memory.
   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem_ff[q_wa] <= q_wd;
      end
      queue_rd_ff <= queue_mem_ff[q_ra];
   end

   assign res = res_ff;

endmodule

FILE: hdl/grid_maze_bfs_step.sv
// Top level of the grid maze breadth-first search block.
//
//   channel   direction   handshake            beat
//   req_      in          req_valid/req_stall  command, cell_column, cell_row, cell_passage
//   rsp_      out         rsp_valid/rsp_stall  visit_column, visit_row, found, exhausted,
//                                              bad_goal
//   csr_      in          csr_valid/csr_ready  csr_index, csr_wdata
//
// One item is worked at a time; req_stall is high until it is finished. The maps hold
// N = MAX_SIDE^2 cells with B = clog2(N) index bits. A begin sweeps the visited map; a
// step on a non-empty queue pops a cell, splits its index with the bit-serial divider and
// then reads the passage and visited bit of each neighbor in turn. After reset the visited
// map is swept while req_stall is high; csr_ready is always high. A result waits in the
// output register, so a stalled rsp_ channel holds up the next item only while that
// register holds an earlier result.
module grid_maze_bfs_step #(
   parameter int MAX_SIDE = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gmb_pkg::CMD_W-1:0]       req_command,
   input  logic [gmb_pkg::COORD_W-1:0]     req_cell_column,
   input  logic [gmb_pkg::COORD_W-1:0]     req_cell_row,
   input  logic [gmb_pkg::PASS_W-1:0]      req_cell_passage,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gmb_pkg::COORD_W-1:0]     rsp_visit_column,
   output logic [gmb_pkg::COORD_W-1:0]     rsp_visit_row,
   output logic                            rsp_found,
   output logic                            rsp_exhausted,
   output logic                            rsp_bad_goal,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gmb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gmb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   gmb_pkg::cfg_type    cfg_ff, cfg_in;
   gmb_pkg::item_type   item;
   gmb_pkg::result_type core_res;
   gmb_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                core_idle;
   logic                core_res_valid;
   logic                res_take;
   logic                item_take;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gmb_pkg::CSR_ROW_COUNT:    cfg_in.row_count    = csr_wdata;
            gmb_pkg::CSR_COLUMN_COUNT: cfg_in.column_count = csr_wdata;
            gmb_pkg::CSR_START_COLUMN: cfg_in.start_column = csr_wdata[gmb_pkg::COORD_W-1:0];
            gmb_pkg::CSR_START_ROW:    cfg_in.start_row    = csr_wdata[gmb_pkg::COORD_W-1:0];
            gmb_pkg::CSR_GOAL_COLUMN:  cfg_in.goal_column  = csr_wdata[gmb_pkg::COORD_W-1:0];
            gmb_pkg::CSR_GOAL_ROW:     cfg_in.goal_row     = csr_wdata[gmb_pkg::COORD_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_count    <= gmb_pkg::RST_ROW_COUNT;
         cfg_ff.column_count <= gmb_pkg::RST_COLUMN_COUNT;
         cfg_ff.start_column <= gmb_pkg::RST_START_COLUMN;
         cfg_ff.start_row    <= gmb_pkg::RST_START_ROW;
         cfg_ff.goal_column  <= gmb_pkg::RST_GOAL_COLUMN;
         cfg_ff.goal_row     <= gmb_pkg::RST_GOAL_ROW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // Input beat goes straight to the sequencer.
   assign req_stall = !core_idle;
   assign item_take = req_valid && !req_stall;

   always_comb begin
      item.command      = req_command;
      item.cell_column  = req_cell_column;
      item.cell_row     = req_cell_row;
      item.cell_passage = req_cell_passage;
   end

   gmb_core #(
      .MAX_SIDE (MAX_SIDE)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item_take (item_take),
      .item      (item),
      .idle      (core_idle),
      .res_valid (core_res_valid),
      .res_take  (res_take),
      .res       (core_res)
   );

   // Output register: loads when empty or when its beat leaves this cycle.
   always_comb begin
      res_take     = core_res_valid && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_visit_column = rsp_data_ff.visit_column;
   assign rsp_visit_row    = rsp_data_ff.visit_row;
   assign rsp_found        = rsp_data_ff.found;
   assign rsp_exhausted    = rsp_data_ff.exhausted;
   assign rsp_bad_goal     = rsp_data_ff.bad_goal;

endmodule

FILE: tb/sv/grid_maze_bfs_step_check.sv
// Checker for the grid maze search block: mirrors its state, predicts every result and compares.
`timescale 1ns / 1ps

module grid_maze_bfs_step_check #(
   parameter int MAX_SIDE = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [gmb_pkg::CMD_W-1:0]      req_command,
   input  logic [gmb_pkg::COORD_W-1:0]    req_cell_column,
   input  logic [gmb_pkg::COORD_W-1:0]    req_cell_row,
   input  logic [gmb_pkg::PASS_W-1:0]     req_cell_passage,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [gmb_pkg::COORD_W-1:0]    rsp_visit_column,
   input  logic [gmb_pkg::COORD_W-1:0]    rsp_visit_row,
   input  logic                           rsp_found,
   input  logic                           rsp_exhausted,
   input  logic                           rsp_bad_goal,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [gmb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gmb_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatch_total,
   output int                             results_owed
);

   localparam int CELLS = MAX_SIDE * MAX_SIDE;

   // Mirror of the maze, the search state and the register file.
   logic [gmb_pkg::PASS_W-1:0] passage_mirror [CELLS];
   bit                         visited_mirror [CELLS];
   int                         frontier [CELLS];
   int                         frontier_head;
   int                         frontier_size;
   gmb_pkg::cfg_type           regs;

   gmb_pkg::result_type        expected_visits [$];
   int                         mismatches = 0;

   assign mismatch_total = mismatches;

   // A size of zero acts as one; anything past the largest side is clamped.
   function automatic int effective_side(input logic [gmb_pkg::SIDE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return int'(v);
   endfunction

   // Pushes drop silently when the queue is full; a pushed cell counts as visited.
   function automatic void enqueue_cell(input int idx);
      if (idx >= CELLS || frontier_size >= CELLS) return;
      frontier[(frontier_head + frontier_size) % CELLS] = idx;
      visited_mirror[idx] = 1'b1;
      frontier_size++;
   endfunction

   // Applies one accepted beat to the mirror and queues the result it must produce.
   function automatic void walk_maze(input gmb_pkg::item_type it);
      int                         rows;
      int                         cols;
      int                         popped;
      int                         col;
      int                         row;
      int                         nc;
      int                         nr;
      int                         nidx;
      bit                         bad;
      bit                         skip;
      logic [gmb_pkg::PASS_W-1:0] here;
      logic [gmb_pkg::DIR_W-1:0]  dir;
      logic [gmb_pkg::DIR_W-1:0]  opposite;
      gmb_pkg::result_type        res;

      rows = effective_side(regs.row_count);
      cols = effective_side(regs.column_count);
      res  = '0;

      case (it.command)
         gmb_pkg::CMD_LOAD: begin
            // Cells outside the configured grid are dropped.
            if (it.cell_column < cols && it.cell_row < rows)
               passage_mirror[it.cell_row * cols + it.cell_column] = it.cell_passage;
         end
         gmb_pkg::CMD_BEGIN: begin
            bad = (regs.goal_column >= cols) || (regs.goal_row >= rows);
            foreach (visited_mirror[i]) visited_mirror[i] = 1'b0;
            frontier_head = 0;
            frontier_size = 0;
            // A bad goal or a start off the grid leaves the queue empty.
            if (!bad && regs.start_column < cols && regs.start_row < rows)
               enqueue_cell(regs.start_row * cols + regs.start_column);
            res.bad_goal = bad;
            expected_visits.insert(expected_visits.size(), res);
         end
         gmb_pkg::CMD_STEP: begin
            if (frontier_size == 0) begin
               res.exhausted = 1'b1;
            end else begin
               popped = frontier[frontier_head];
               if (popped >= CELLS) popped = 0;
               frontier_head = (frontier_head + 1) % CELLS;
               frontier_size--;
               // The index is split by the current stride, even after a resize.
               col = popped % cols;
               row = popped / cols;
               res.visit_column = col[gmb_pkg::COORD_W-1:0];
               res.visit_row    = row[gmb_pkg::COORD_W-1:0];
               if (col == regs.goal_column && row == regs.goal_row) begin
                  res.found = 1'b1;
               end else begin
                  here = passage_mirror[popped];
                  for (int d = 0; d < 4; d++) begin
                     dir  = d[gmb_pkg::DIR_W-1:0];
                     // North/south and east/west differ only in the low bit.
                     opposite = dir ^ 2'b01;
                     nc   = col;
                     nr   = row;
                     skip = 1'b0;
                     case (dir)
                        gmb_pkg::DIR_NORTH: if (row == 0) skip = 1'b1; else nr = row - 1;
                        gmb_pkg::DIR_SOUTH: nr = row + 1;
                        gmb_pkg::DIR_EAST:  nc = col + 1;
                        gmb_pkg::DIR_WEST:  if (col == 0) skip = 1'b1; else nc = col - 1;
                        default: ;
                     endcase
                     if (!skip && nc < cols && nr < rows) begin
                        nidx = nr * cols + nc;
                        // Joined when either cell points at the other.
                        if (!visited_mirror[nidx] &&
                            (here == dir || passage_mirror[nidx] == opposite))
                           enqueue_cell(nidx);
                     end
                  end
               end
            end
            expected_visits.insert(expected_visits.size(), res);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      gmb_pkg::result_type want;
      if (reset) begin
         regs.row_count    = gmb_pkg::RST_ROW_COUNT;
         regs.column_count = gmb_pkg::RST_COLUMN_COUNT;
         regs.start_column = gmb_pkg::RST_START_COLUMN;
         regs.start_row    = gmb_pkg::RST_START_ROW;
         regs.goal_column  = gmb_pkg::RST_GOAL_COLUMN;
         regs.goal_row     = gmb_pkg::RST_GOAL_ROW;
         foreach (visited_mirror[i]) visited_mirror[i] = 1'b0;
         frontier_head = 0;
         frontier_size = 0;
         expected_visits.delete();
      end else begin
         // Result beat: compare against the oldest prediction, field by field.
         if (rsp_valid && !rsp_stall) begin
            if (expected_visits.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result beat: col %0d row %0d found %0b exh %0b bad %0b",
                           rsp_visit_column, rsp_visit_row, rsp_found, rsp_exhausted,
                           rsp_bad_goal);
               mismatches++;
            end else begin
               want = expected_visits[0];
               expected_visits.delete(0);
               if (rsp_visit_column !== want.visit_column ||
                   rsp_visit_row    !== want.visit_row    ||
                   rsp_found        !== want.found        ||
                   rsp_exhausted    !== want.exhausted    ||
                   rsp_bad_goal     !== want.bad_goal) begin
                  if (mismatches < 10)
                     $display("mismatch at %0t: want %0d/%0d f%0b e%0b b%0b, got %0d/%0d f%0b e%0b b%0b",
                              $realtime, want.visit_column, want.visit_row, want.found,
                              want.exhausted, want.bad_goal, rsp_visit_column, rsp_visit_row,
                              rsp_found, rsp_exhausted, rsp_bad_goal);
                  mismatches++;
               end
            end
         end

         // Register writes; the top bit of coordinate writes is dropped.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gmb_pkg::CSR_ROW_COUNT:    regs.row_count    = csr_wdata;
               gmb_pkg::CSR_COLUMN_COUNT: regs.column_count = csr_wdata;
               gmb_pkg::CSR_START_COLUMN: regs.start_column = csr_wdata[gmb_pkg::COORD_W-1:0];
               gmb_pkg::CSR_START_ROW:    regs.start_row    = csr_wdata[gmb_pkg::COORD_W-1:0];
               gmb_pkg::CSR_GOAL_COLUMN:  regs.goal_column  = csr_wdata[gmb_pkg::COORD_W-1:0];
               gmb_pkg::CSR_GOAL_ROW:     regs.goal_row     = csr_wdata[gmb_pkg::COORD_W-1:0];
               default: ;
            endcase
         end

         // Command beat.
         if (req_valid && !req_stall)
            walk_maze('{command:      req_command,
                        cell_column:  req_cell_column,
                        cell_row:     req_cell_row,
                        cell_passage: req_cell_passage});
      end
      results_owed <= expected_visits.size();
   end

endmodule

FILE: tb/sv/grid_maze_bfs_step_test.sv
// Top of the grid maze search testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module grid_maze_bfs_step_test;

   localparam int ITEMS          = 1550;
   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int MAX_SIDE_TB    = 32;

   // Codes the package leaves unnamed.
   localparam logic [gmb_pkg::CMD_W-1:0]     CMD_UNUSED   = 2'd3;
   localparam logic [gmb_pkg::PASS_W-1:0]    PASS_NONE    = 3'd4;
   localparam logic [gmb_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [gmb_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [gmb_pkg::CMD_W-1:0]      req_command = gmb_pkg::CMD_LOAD;
   logic [gmb_pkg::COORD_W-1:0]    req_cell_column = '0;
   logic [gmb_pkg::COORD_W-1:0]    req_cell_row = '0;
   logic [gmb_pkg::PASS_W-1:0]     req_cell_passage = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [gmb_pkg::COORD_W-1:0]    rsp_visit_column;
   logic [gmb_pkg::COORD_W-1:0]    rsp_visit_row;
   logic                           rsp_found;
   logic                           rsp_exhausted;
   logic                           rsp_bad_goal;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [gmb_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [gmb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int                    mismatch_total;
   int                    results_owed;
   int                    sent_items = 0;
   int                    quiet_cycles = 0;
   logic                  calm = 1'b0;

   grid_maze_bfs_step dut (.*);

   grid_maze_bfs_step_check checker_i (.*);

   always #5 clock = ~clock;

   // The result side stalls at random except during calm stretches.
   always @(posedge clock) rsp_stall <= !calm && ($urandom_range(0, 99) < 36);

   // Watchdog: too long without any beat on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Mostly real directions so that walks get somewhere.
   function automatic logic [gmb_pkg::PASS_W-1:0] random_passage();
      if ($urandom_range(0, 9) < 8)
         return gmb_pkg::PASS_W'($urandom_range(gmb_pkg::DIR_NORTH, gmb_pkg::DIR_WEST));
      return gmb_pkg::PASS_W'($urandom_range(PASS_NONE, 7));
   endfunction

   // Sizes are mostly small, with the largest, zero and past-the-top values mixed in.
   function automatic logic [gmb_pkg::SIDE_W-1:0] pick_side();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return gmb_pkg::SIDE_W'($urandom_range(1, 8));
      if (r < 85) return gmb_pkg::SIDE_W'($urandom_range(9, 32));
      if (r < 92) return 6'd32;
      if (r < 96) return 6'd0;
      return gmb_pkg::SIDE_W'($urandom_range(33, 63));
   endfunction

   // Usually a coordinate inside the given side, sometimes anything the port carries.
   function automatic logic [gmb_pkg::CSR_DATA_W-1:0] pick_coord(
         input logic [gmb_pkg::SIDE_W-1:0] side);
      if (side >= 1 && side <= 32 && $urandom_range(0, 4) != 0)
         return gmb_pkg::CSR_DATA_W'($urandom_range(0, side - 1));
      return gmb_pkg::CSR_DATA_W'($urandom_range(0, 63));
   endfunction

   // Drives one command beat; valid stays high after acceptance until the next call or the next wait for idle.
   task automatic send_item(input logic [gmb_pkg::CMD_W-1:0] cmd,
                            input logic [gmb_pkg::COORD_W-1:0] col,
                            input logic [gmb_pkg::COORD_W-1:0] row,
                            input logic [gmb_pkg::PASS_W-1:0] passage);
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_cell_column  <= col;
      req_cell_row     <= row;
      req_cell_passage <= passage;
      do @(posedge clock); while (req_stall);
      if (cmd != CMD_UNUSED) sent_items++;
   endtask

   task automatic write_reg(input logic [gmb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [gmb_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Lets every owed result drain, then gives a trailing load time to finish.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                         phase;
      int                         nloads;
      int                         nsteps;
      int                         r;
      bit                         resized;
      logic [gmb_pkg::SIDE_W-1:0] rows_v;
      logic [gmb_pkg::SIDE_W-1:0] cols_v;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: a 2x2 maze walked to its goal, then drained.
      write_reg(gmb_pkg::CSR_ROW_COUNT, 6'd2);
      write_reg(gmb_pkg::CSR_COLUMN_COUNT, 6'd2);
      write_reg(gmb_pkg::CSR_START_COLUMN, 6'd0);
      write_reg(gmb_pkg::CSR_START_ROW, 6'd0);
      write_reg(gmb_pkg::CSR_GOAL_COLUMN, 6'd1);
      write_reg(gmb_pkg::CSR_GOAL_ROW, 6'd1);
      send_item(gmb_pkg::CMD_LOAD, 5'd0, 5'd0, gmb_pkg::DIR_EAST);
      send_item(gmb_pkg::CMD_LOAD, 5'd1, 5'd0, PASS_NONE);
      // Odd passage value, acts as none.
      send_item(gmb_pkg::CMD_LOAD, 5'd0, 5'd1, 3'd7);
      send_item(gmb_pkg::CMD_LOAD, 5'd1, 5'd1, gmb_pkg::DIR_NORTH);
      // Off the grid, must be ignored.
      send_item(gmb_pkg::CMD_LOAD, 5'd31, 5'd31, 3'd5);
      send_item(CMD_UNUSED, 5'd31, 5'd31, gmb_pkg::DIR_SOUTH);
      send_item(gmb_pkg::CMD_BEGIN, 5'd0, 5'd0, 3'd0);
      repeat (4) send_item(gmb_pkg::CMD_STEP, 5'd0, 5'd0, 3'd0);

      // Goal outside the grid: flagged, and the queue stays empty.
      wait_until_idle();
      write_reg(gmb_pkg::CSR_GOAL_COLUMN, 6'd2);
      send_item(gmb_pkg::CMD_BEGIN, 5'd0, 5'd0, 3'd0);
      send_item(gmb_pkg::CMD_STEP, 5'd0, 5'd0, 3'd0);

      // Start outside the grid: nothing is queued.
      wait_until_idle();
      write_reg(gmb_pkg::CSR_GOAL_COLUMN, 6'd1);
      write_reg(gmb_pkg::CSR_START_ROW, 6'd2);
      send_item(gmb_pkg::CMD_BEGIN, 5'd0, 5'd0, 3'd0);
      send_item(gmb_pkg::CMD_STEP, 5'd0, 5'd0, 3'd0);

      // Fill the whole store at full stride so no later read finds an unwritten cell.
      wait_until_idle();
      write_reg(gmb_pkg::CSR_ROW_COUNT, 6'd32);
      write_reg(gmb_pkg::CSR_COLUMN_COUNT, 6'd32);
      for (int i = 0; i < MAX_SIDE_TB * MAX_SIDE_TB; i++) begin
         calm <= (i >= 300 && i < 700);
         send_item(gmb_pkg::CMD_LOAD, gmb_pkg::COORD_W'(i % 32), gmb_pkg::COORD_W'(i / 32),
                   random_passage());
      end
      calm <= 1'b0;

      // Random searches: new settings, a few loads, a begin, then steps mixed with other beats.
      phase = 0;
      while (sent_items < ITEMS) begin
         wait_until_idle();
         rows_v = (phase == 0) ? 6'd32 : pick_side();
         cols_v = (phase == 0) ? 6'd32 : pick_side();
         write_reg(gmb_pkg::CSR_ROW_COUNT, rows_v);
         write_reg(gmb_pkg::CSR_COLUMN_COUNT, cols_v);
         write_reg(gmb_pkg::CSR_START_COLUMN, pick_coord(cols_v));
         write_reg(gmb_pkg::CSR_START_ROW, pick_coord(rows_v));
         write_reg(gmb_pkg::CSR_GOAL_COLUMN, pick_coord(cols_v));
         write_reg(gmb_pkg::CSR_GOAL_ROW, pick_coord(rows_v));
         if ($urandom_range(0, 9) == 0)
            write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                      gmb_pkg::CSR_DATA_W'($urandom_range(0, 63)));
         calm <= (phase % 7 == 3);

         nloads = $urandom_range(0, 3);
         repeat (nloads)
            send_item(gmb_pkg::CMD_LOAD, gmb_pkg::COORD_W'(pick_coord(cols_v)),
                      gmb_pkg::COORD_W'(pick_coord(rows_v)), random_passage());
         send_item(gmb_pkg::CMD_BEGIN, gmb_pkg::COORD_W'($urandom_range(0, 31)),
                   gmb_pkg::COORD_W'($urandom_range(0, 31)),
                   gmb_pkg::PASS_W'($urandom_range(0, 7)));

         nsteps  = $urandom_range(1, 24);
         resized = 1'b0;
         repeat (nsteps) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               send_item(CMD_UNUSED, gmb_pkg::COORD_W'($urandom_range(0, 31)),
                         gmb_pkg::COORD_W'($urandom_range(0, 31)),
                         gmb_pkg::PASS_W'($urandom_range(0, 7)));
            end else if (r < 12) begin
               send_item(gmb_pkg::CMD_LOAD, gmb_pkg::COORD_W'(pick_coord(cols_v)),
                         gmb_pkg::COORD_W'(pick_coord(rows_v)), random_passage());
            end else if (r < 15 && !resized) begin
               // Resize in the middle of a search; popped cells get split by the new stride.
               wait_until_idle();
               rows_v = pick_side();
               cols_v = pick_side();
               write_reg(gmb_pkg::CSR_ROW_COUNT, rows_v);
               write_reg(gmb_pkg::CSR_COLUMN_COUNT, cols_v);
               resized = 1'b1;
            end else begin
               send_item(gmb_pkg::CMD_STEP, gmb_pkg::COORD_W'($urandom_range(0, 31)),
                         gmb_pkg::COORD_W'($urandom_range(0, 31)),
                         gmb_pkg::PASS_W'($urandom_range(0, 7)));
            end
         end
         phase++;
      end

      calm <= 1'b0;
      wait_until_idle();
      if (mismatch_total == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
